/* rtl/rlpc_pkg.sv */
// Shared types, widths and constants for the RMS level to PWM compare block.
// Used by rlpc_alu, rlpc_core and the top level rms_level_to_pwm_compare.
package rlpc_pkg;

  localparam int SAMPLE_WIDTH        = 16;
  localparam int ALPHA_W             = 25;
  localparam int FS_W                = 16;
  localparam int PERIOD_W            = 16;
  localparam int LEVEL_W             = 16;
  localparam int MEAN_W              = 48;
  localparam int ALPHA_FRAC_BITS_DEF = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  // Shared multiplier and adder widths.
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int AS_W    = 50;

  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 25'd3355;
  localparam logic [FS_W-1:0]     FS_RST     = 16'd4096;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd30000;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;

  typedef struct packed {
    logic                           command;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] compare_value;
    logic [LEVEL_W-1:0]  rms_level;
  } out_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]  alpha_q;
    logic [FS_W-1:0]     full_scale;
    logic [PERIOD_W-1:0] pwm_period;
  } cfg_t;

  typedef struct packed {
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [AS_W-1:0]    as_a;
    logic [AS_W-1:0]    as_b;
    logic               as_sub;
  } alu_req_t;

  typedef struct packed {
    logic [MUL_P_W-1:0] mul_p;
    logic [AS_W-1:0]    as_s;
    logic               as_c;
  } alu_rsp_t;

endpackage

/* rtl/rlpc_alu.sv */
// Shared arithmetic unit: one unsigned multiplier and one add/subtract unit.
// Depends on rlpc_pkg for operand widths and the request/response structs.
module rlpc_alu (
  input  rlpc_pkg::alu_req_t req,
  output rlpc_pkg::alu_rsp_t rsp
);

  logic [rlpc_pkg::AS_W:0] sum;

  // For a subtract, carry out high means as_a >= as_b.
  assign sum = {1'b0, req.as_a}
             + {1'b0, req.as_b ^ {rlpc_pkg::AS_W{req.as_sub}}}
             + {{rlpc_pkg::AS_W{1'b0}}, req.as_sub};

  assign rsp.mul_p = rlpc_pkg::MUL_P_W'(req.mul_a) * rlpc_pkg::MUL_P_W'(req.mul_b);
  assign rsp.as_s  = sum[rlpc_pkg::AS_W-1:0];
  assign rsp.as_c  = sum[rlpc_pkg::AS_W];

endmodule

/* rtl/rlpc_core.sv */
// Sequencer and working registers: mean-square update, square root, divide.
// Depends on rlpc_pkg; drives the shared rlpc_alu through a request struct.
module rlpc_core #(
  parameter int ALPHA_FRAC_BITS = rlpc_pkg::ALPHA_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rlpc_pkg::in_t      item,
  input  rlpc_pkg::cfg_t     cfg,
  output rlpc_pkg::alu_req_t alu_req,
  input  rlpc_pkg::alu_rsp_t alu_rsp,
  output logic               ready,
  output logic               res_valid,
  output rlpc_pkg::out_t     res,
  input  logic               res_ack
);

  localparam int SW = rlpc_pkg::SAMPLE_WIDTH;
  localparam int MW = rlpc_pkg::MEAN_W;
  localparam logic [33:0] ALPHA_ONE = 34'(1) << ALPHA_FRAC_BITS;
  localparam logic [rlpc_pkg::MUL_P_W-1:0] SQ_MAX = rlpc_pkg::MUL_P_W'(32'hFFFF_FFFF);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_SQ    = 14'b00000000000010,
    ST_DIFF  = 14'b00000000000100,
    ST_NEG   = 14'b00000000001000,
    ST_LO    = 14'b00000000010000,
    ST_HI    = 14'b00000000100000,
    ST_STEP  = 14'b00000001000000,
    ST_UPD   = 14'b00000010000000,
    ST_SQRT  = 14'b00000100000000,
    ST_CMPFS = 14'b00001000000000,
    ST_MULP  = 14'b00010000000000,
    ST_DIV   = 14'b00100000000000,
    ST_FIN   = 14'b01000000000000,
    ST_DONE  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SW-1:0]                   mag_r;
  logic [rlpc_pkg::MUL_P_W-1:0]    prod_r;
  logic [rlpc_pkg::MUL_P_W-1:0]    lo_r;
  logic [MW-1:0]                   d_r;
  logic                            neg_r;
  logic [MW-1:0]                   step_r;
  logic [MW-1:0]                   mean_r;
  logic [31:0]                     x_r;
  logic [31:0]                     res_r;
  logic [3:0]                      cnt_r;
  logic [15:0]                     rem_r;
  logic [15:0]                     num_r;
  logic [rlpc_pkg::PERIOD_W-1:0]   cmp_r;

  logic [SW-1:0]                sample_u;
  logic [SW-1:0]                mag;
  logic [rlpc_pkg::ALPHA_W-1:0] alpha_sat;
  logic [MW-1:0]                sq48;
  logic [73:0]                  p_full;
  logic [73:0]                  p_shift;
  logic [4:0]                   bit_sh;
  logic [31:0]                  sq_bit;
  logic [31:0]                  sq_try;
  logic [16:0]                  rem2;

  assign sample_u  = item.sample;
  assign mag       = sample_u[SW-1] ? (~sample_u + 1'b1) : sample_u;
  assign alpha_sat = ({9'b0, cfg.alpha_q} > ALPHA_ONE) ? ALPHA_ONE[rlpc_pkg::ALPHA_W-1:0]
                                                      : cfg.alpha_q;
  assign sq48      = (prod_r > SQ_MAX) ? {MW{1'b1}} : {prod_r[31:0], 16'h0000};
  // alpha*d = hi*2^24 + lo; the upper part comes from the adder
  assign p_full    = {alu_rsp.as_s, lo_r[23:0]};
  assign p_shift   = p_full >> ALPHA_FRAC_BITS;
  assign bit_sh    = {~cnt_r, 1'b0};
  assign sq_bit    = 32'd1 << bit_sh;
  assign sq_try    = res_r + sq_bit;
  assign rem2      = {rem_r, num_r[15]};

  // Operand selection for the shared unit.
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      ST_SQ: begin
        alu_req.mul_a = rlpc_pkg::MUL_A_W'(mag_r);
        alu_req.mul_b = rlpc_pkg::MUL_B_W'(mag_r);
      end
      ST_DIFF: begin
        alu_req.as_a   = rlpc_pkg::AS_W'(sq48);
        alu_req.as_b   = rlpc_pkg::AS_W'(mean_r);
        alu_req.as_sub = 1'b1;
      end
      ST_NEG: begin
        alu_req.as_b   = rlpc_pkg::AS_W'(d_r);
        alu_req.as_sub = 1'b1;
      end
      ST_LO: begin
        alu_req.mul_a = alpha_sat;
        alu_req.mul_b = d_r[23:0];
      end
      ST_HI: begin
        alu_req.mul_a = alpha_sat;
        alu_req.mul_b = d_r[47:24];
      end
      ST_STEP: begin
        alu_req.as_a = rlpc_pkg::AS_W'(prod_r);
        alu_req.as_b = rlpc_pkg::AS_W'(lo_r[48:24]);
      end
      ST_UPD: begin
        alu_req.as_a   = rlpc_pkg::AS_W'(mean_r);
        alu_req.as_b   = rlpc_pkg::AS_W'(step_r);
        alu_req.as_sub = neg_r;
      end
      ST_SQRT: begin
        alu_req.as_a   = rlpc_pkg::AS_W'(x_r);
        alu_req.as_b   = rlpc_pkg::AS_W'(sq_try);
        alu_req.as_sub = 1'b1;
      end
      ST_CMPFS: begin
        alu_req.as_a   = rlpc_pkg::AS_W'(res_r[15:0]);
        alu_req.as_b   = rlpc_pkg::AS_W'(cfg.full_scale);
        alu_req.as_sub = 1'b1;
      end
      ST_MULP: begin
        alu_req.mul_a = rlpc_pkg::MUL_A_W'(res_r[15:0]);
        alu_req.mul_b = rlpc_pkg::MUL_B_W'(cfg.pwm_period);
      end
      ST_DIV: begin
        alu_req.as_a   = rlpc_pkg::AS_W'(rem2);
        alu_req.as_b   = rlpc_pkg::AS_W'(cfg.full_scale);
        alu_req.as_sub = 1'b1;
      end
      ST_FIN: begin
        alu_req.as_a   = rlpc_pkg::AS_W'(cfg.pwm_period);
        alu_req.as_b   = rlpc_pkg::AS_W'(num_r);
        alu_req.as_sub = 1'b1;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (item.command == rlpc_pkg::CMD_TICK) ? ST_SQRT : ST_SQ;
        end
      end
      ST_SQ:    state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = alu_rsp.as_c ? ST_LO : ST_NEG;
      ST_NEG:   state_nxt = ST_LO;
      ST_LO:    state_nxt = ST_HI;
      ST_HI:    state_nxt = ST_STEP;
      ST_STEP:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_IDLE;
      ST_SQRT:  state_nxt = (cnt_r == 4'd15) ? ST_CMPFS : ST_SQRT;
      ST_CMPFS: state_nxt = alu_rsp.as_c ? ST_DONE : ST_MULP;
      ST_MULP:  state_nxt = ST_DIV;
      ST_DIV:   state_nxt = (cnt_r == 4'd15) ? ST_FIN : ST_DIV;
      ST_FIN:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mean_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (start) begin
            mag_r <= mag;
            x_r   <= mean_r[47:16];
            res_r <= '0;
          end
        end
        ST_SQ:   prod_r <= alu_rsp.mul_p;
        ST_DIFF: begin
          d_r   <= alu_rsp.as_s[MW-1:0];
          neg_r <= ~alu_rsp.as_c;
        end
        ST_NEG:  d_r <= alu_rsp.as_s[MW-1:0];
        ST_LO:   prod_r <= alu_rsp.mul_p;
        ST_HI: begin
          lo_r   <= prod_r;
          prod_r <= alu_rsp.mul_p;
        end
        ST_STEP: step_r <= p_shift[MW-1:0];
        ST_UPD:  mean_r <= alu_rsp.as_s[MW-1:0];
        ST_SQRT: begin
          cnt_r <= cnt_r + 4'd1;
          if (alu_rsp.as_c) begin
            x_r   <= alu_rsp.as_s[31:0];
            res_r <= (res_r >> 1) + sq_bit;
          end else begin
            res_r <= res_r >> 1;
          end
        end
        ST_CMPFS: begin
          cmp_r <= '0;
          cnt_r <= '0;
        end
        ST_MULP: begin
          // numerator high half is below full_scale since rms < full_scale
          rem_r <= alu_rsp.mul_p[31:16];
          num_r <= alu_rsp.mul_p[15:0];
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 4'd1;
          rem_r <= alu_rsp.as_c ? alu_rsp.as_s[15:0] : rem2[15:0];
          num_r <= {num_r[14:0], alu_rsp.as_c};
        end
        ST_FIN:  cmp_r <= alu_rsp.as_s[rlpc_pkg::PERIOD_W-1:0];
        ST_DONE: cnt_r <= '0;
        default: cnt_r <= '0;
      endcase
    end
  end

  assign ready             = (state_r == ST_IDLE);
  assign res_valid         = (state_r == ST_DONE);
  assign res.compare_value = cmp_r;
  assign res.rms_level     = res_r[rlpc_pkg::LEVEL_W-1:0];

endmodule

/* rtl/rms_level_to_pwm_compare.sv */
// Top level: configuration registers, input handshake, output register.
// Depends on rlpc_pkg, rlpc_alu and rlpc_core.
//
//  channel  dir  handshake          payload
//  in_      in   in_valid/in_stall  rlpc_pkg::in_t  {command, sample}
//  out_     out  out_valid/out_stall rlpc_pkg::out_t {compare_value, rms_level}
//  cfg_     in   cfg_we             cfg_index, cfg_data
//
// After acceptance a sample occupies the shared multiplier/adder for its steps:
// square, difference, optional negate, two partial products, sum, update.
// A tick runs 16 square-root steps, a full-scale compare, one multiply and 16
// restoring divide steps on the shared adder, the subtract, then the hand-off
// to the output register; at full scale it goes from the compare to the hand-off.
// Synchronous active-low reset clears the mean square, the sequencer and the
// output valid, and loads the register defaults.
// in_stall is high while the sequencer is busy; a finished result waits in the
// core until the output register is free, so out_stall holds back further input.
module rms_level_to_pwm_compare #(
  parameter int ALPHA_FRAC_BITS = rlpc_pkg::ALPHA_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rlpc_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rlpc_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [rlpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rlpc_pkg::cfg_t     cfg_r;
  rlpc_pkg::alu_req_t alu_req;
  rlpc_pkg::alu_rsp_t alu_rsp;
  rlpc_pkg::out_t     core_res;
  rlpc_pkg::out_t     out_data_r;
  logic               out_valid_r;
  logic               core_ready;
  logic               core_res_valid;
  logic               in_accept;
  logic               out_load;

  assign in_accept = in_valid & core_ready;
  assign in_stall  = ~core_ready;
  assign out_load  = core_res_valid & (~out_valid_r | ~out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_q    <= rlpc_pkg::ALPHA_RST;
      cfg_r.full_scale <= rlpc_pkg::FS_RST;
      cfg_r.pwm_period <= rlpc_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlpc_pkg::REG_ALPHA:  cfg_r.alpha_q    <= cfg_data;
        rlpc_pkg::REG_FS:     cfg_r.full_scale <= cfg_data[rlpc_pkg::FS_W-1:0];
        rlpc_pkg::REG_PERIOD: cfg_r.pwm_period <= cfg_data[rlpc_pkg::PERIOD_W-1:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rlpc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  rlpc_core #(
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_accept),
    .item      (in_data),
    .cfg       (cfg_r),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp),
    .ready     (core_ready),
    .res_valid (core_res_valid),
    .res       (core_res),
    .res_ack   (out_load)
  );

  // An accepted transaction always leaves the sequencer busy for a while.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !core_ready)
    else $error("sequencer still ready after accepting a transaction");

  // The compare value never exceeds the programmed period.
  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (core_res.compare_value <= cfg_r.pwm_period))
    else $error("compare value above pwm period");

  // A level at or above full scale gives zero duty compare.
  a_cmp_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (core_res.rms_level >= cfg_r.full_scale)) |->
      (core_res.compare_value == '0))
    else $error("compare value not saturated at full scale");

endmodule
